>>> src/dtti_pkg.sv
// Shared types and constants for the decimal text to integer converter.
package dtti_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_BIT = 2;

   localparam logic [15:0] SEARCH_LIMIT_RESET = 16'd1024;
   localparam logic WIDE_MODE_RESET = 1'b1;

   localparam logic [63:0] WIDE_TENTH = 64'd1844674407370955161;
   localparam logic [63:0] NARROW_TENTH = 64'd6553;
   localparam logic [3:0] LAST_SAFE_DIGIT = 4'd5;
   localparam logic [15:0] INDEX_MAX = 16'hFFFF;

   typedef enum logic {
      REG_SEARCH_LIMIT = 1'b0,
      REG_WIDE_MODE = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NONE = 2'd1,
      ST_OVER = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_SEEK = 2'd0,
      PH_DIGITS = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic digit_hit;
      logic [3:0] digit_val;
      logic first;
      logic last;
   } item_type;

   typedef struct packed {
      logic load;
      phase_type phase;
   } back_status_type;

endpackage

>>> src/dtti_front.sv
// Front end: accepts request bytes, classifies them and pushes them to the queue.
module dtti_front
   import dtti_pkg::*;
(
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_char_byte,
   input logic req_first_byte,
   input logic req_last_byte,
   input logic q_full,
   output logic q_push,
   output item_type q_item
);

   always_comb begin
      q_item.digit_hit = req_char_byte inside {[8'h30:8'h39]};
      q_item.digit_val = req_char_byte[3:0];
      q_item.first = req_first_byte;
      q_item.last = req_last_byte;
   end

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full;

endmodule

>>> src/dtti_queue.sv
// Small FIFO of classified bytes between the front and back ends.
module dtti_queue
   import dtti_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input logic clock,
   input logic reset,
   input logic push,
   input item_type push_item,
   output logic full,
   input logic pop,
   output logic head_valid,
   output item_type head_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   item_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/dtti_back.sv
// Back end: runs the digit search and accumulation and holds the response register.
module dtti_back
   import dtti_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic head_valid,
   input item_type head_item,
   output logic pop,
   input logic [15:0] search_limit,
   input logic wide_mode,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [63:0] rsp_number_value,
   output logic [1:0] rsp_parse_status,
   output back_status_type back_status
);

   phase_type phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] index_ff, index_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] value_ff, value_in;
   status_type status_ff, status_in;

   phase_type cur_phase;
   logic [63:0] cur_acc;
   logic [15:0] cur_index;
   logic [63:0] tenth;
   logic [63:0] acc_next;
   logic at_end, index_over, emit;
   logic [63:0] emit_value;
   status_type emit_status;

   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cur_phase = head_item.first ? PH_SEEK : phase_ff;
      cur_acc = head_item.first ? '0 : acc_ff;
      cur_index = head_item.first ? '0 : index_ff;
      tenth = wide_mode ? WIDE_TENTH : NARROW_TENTH;
      acc_next = (cur_acc << 3) + (cur_acc << 1) + {60'd0, head_item.digit_val};
      at_end = head_item.last || (({1'b0, cur_index} + 17'd1) >= {1'b0, search_limit});
      index_over = (cur_index >= search_limit);

      phase_in = phase_ff;
      acc_in = acc_ff;
      index_in = index_ff;
      emit = 1'b0;
      emit_value = '0;
      emit_status = ST_OK;

      if (pop) begin
         phase_in = cur_phase;
         acc_in = cur_acc;
         index_in = (cur_index == INDEX_MAX) ? cur_index : cur_index + 16'd1;
         case (cur_phase)
            PH_SEEK: begin
               if (index_over) begin
                  emit = 1'b1;
                  emit_status = ST_NONE;
               end else if (head_item.digit_hit) begin
                  acc_in = {60'd0, head_item.digit_val};
                  phase_in = PH_DIGITS;
                  if (at_end) begin
                     emit = 1'b1;
                     emit_value = {60'd0, head_item.digit_val};
                  end
               end else if (at_end) begin
                  emit = 1'b1;
                  emit_status = ST_NONE;
               end
            end
            PH_DIGITS: begin
               if (!head_item.digit_hit || index_over) begin
                  emit = 1'b1;
                  emit_value = cur_acc;
               end else if ((cur_acc > tenth) ||
                            ((cur_acc == tenth) && (head_item.digit_val > LAST_SAFE_DIGIT))) begin
                  emit = 1'b1;
                  emit_value = cur_acc;
                  emit_status = ST_OVER;
               end else begin
                  acc_in = acc_next;
                  if (at_end) begin
                     emit = 1'b1;
                     emit_value = acc_next;
                  end
               end
            end
            default: begin
               phase_in = cur_phase;
            end
         endcase
         if (emit) begin
            phase_in = PH_DONE;
         end
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      value_in = value_ff;
      status_in = status_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         value_in = emit_value;
         status_in = emit_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         acc_ff <= '0;
         index_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         index_ff <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      status_ff <= status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_number_value = value_ff;
   assign rsp_parse_status = status_ff;
   assign back_status.load = emit;
   assign back_status.phase = phase_ff;

endmodule

>>> src/decimal_text_to_integer.sv
// Top level: finds the first decimal digit run in a byte string and converts it.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  char_byte, first_byte, last_byte
//   rsp      out        rsp_valid/rsp_stall  number_value, parse_status
//   csr      in         APB psel/penable     search_limit, wide_mode
//
// One byte per cycle sustained unless a waiting response is stalled; an accepted
// byte is written to the queue, then popped into the parse and response registers.
// The queue holds QueueDepth bytes, so up to QueueDepth requests are still accepted
// while a response waits; then req_stall holds until the response leaves.
// Reset is synchronous and clears the queue, the parse state and the response valid.
module decimal_text_to_integer
   import dtti_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_char_byte,
   input logic req_first_byte,
   input logic req_last_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [63:0] rsp_number_value,
   output logic [1:0] rsp_parse_status,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   logic [15:0] search_limit_ff, search_limit_in;
   logic wide_mode_ff, wide_mode_in;
   logic csr_write;
   reg_index_type csr_index;

   logic q_full, q_push, q_pop, q_head_valid;
   item_type q_push_item, q_head_item;
   back_status_type back_status;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = reg_index_type'(csr_paddr[CSR_INDEX_BIT]);

   always_comb begin
      search_limit_in = search_limit_ff;
      wide_mode_in = wide_mode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SEARCH_LIMIT: search_limit_in = csr_pwdata[15:0];
            REG_WIDE_MODE: wide_mode_in = csr_pwdata[0];
            default: search_limit_in = search_limit_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SEARCH_LIMIT: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, search_limit_ff};
         REG_WIDE_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, wide_mode_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_limit_ff <= SEARCH_LIMIT_RESET;
         wide_mode_ff <= WIDE_MODE_RESET;
      end else begin
         search_limit_ff <= search_limit_in;
         wide_mode_ff <= wide_mode_in;
      end
   end

   dtti_front u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_byte(req_char_byte),
      .req_first_byte(req_first_byte),
      .req_last_byte(req_last_byte),
      .q_full(q_full),
      .q_push(q_push),
      .q_item(q_push_item)
   );

   dtti_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(q_push_item),
      .full(q_full),
      .pop(q_pop),
      .head_valid(q_head_valid),
      .head_item(q_head_item)
   );

   dtti_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(q_head_valid),
      .head_item(q_head_item),
      .pop(q_pop),
      .search_limit(search_limit_ff),
      .wide_mode(wide_mode_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_number_value(rsp_number_value),
      .rsp_parse_status(rsp_parse_status),
      .back_status(back_status)
   );

   a_load_ends_string: assert property (@(posedge clock) disable iff (reset)
      back_status.load |=> (back_status.phase == PH_DONE) && rsp_valid)
      else $error("response load did not close the string");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_parse_status == ST_NONE)) |-> (rsp_number_value == 64'd0))
      else $error("no-digit response carries a nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_parse_status == ST_OK) || (rsp_parse_status == ST_NONE) ||
                     (rsp_parse_status == ST_OVER)))
      else $error("response status code out of range");

   a_no_pop_while_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !q_pop)
      else $error("queue popped while response is stalled");

endmodule
